FILE: hdl/fft_shift_2d_reorder_defines.svh
// assertion macros for the fft shift 2d reorder block
// no dependencies; expects clk and rst_n in the including module
`ifndef FFT_SHIFT_2D_REORDER_DEFINES_SVH
`define FFT_SHIFT_2D_REORDER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define FSR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FSR_ASSERT(label, ante, cons, msg)
`define FSR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/fsr_pkg.sv
// shared constants for the fft shift 2d reorder block
// no dependencies
`timescale 1ns / 1ps

package fsr_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int SAMPLE_BITS = 64;

  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int BANK_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int STORE_DEPTH = 2 * BANK_DEPTH;
  localparam int IDX_W       = $clog2(BANK_DEPTH);
  localparam int TOTAL_W     = IDX_W + 1;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int CNT_W       = $clog2(IDX_W);

  // configuration register fields
  localparam int SIZE_W      = 7;
  localparam int MODE_W      = 2;
  localparam int HOT_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_COL    = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_FFTSHIFT  = 2'd0,
    MODE_IFFTSHIFT = 2'd1,
    MODE_UNC_FWD   = 2'd2,
    MODE_UNC_INV   = 2'd3
  } shift_mode_t;

endpackage

FILE: hdl/fsr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module fsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/fft_shift_2d_reorder.sv
// a result reaches out_valid through the registered store read (read stage) and the output register
// throughput: one input transaction per clock while out_ready stays high and no recompute
//   pass runs; the store does one write and one read per clock, in opposite banks
// reset and every config write start a recompute pass (one shared divider,
//   one quotient bit per cycle); in_ready stays low during it, config writes still taken
// frame store contents are not cleared by reset
`timescale 1ns / 1ps

`include "fft_shift_2d_reorder_defines.svh"

module fft_shift_2d_reorder (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // raster sample input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [fsr_pkg::SAMPLE_BITS-1:0]  in_sample,
  // reordered sample output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fsr_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                             out_frame_last
);

  import fsr_pkg::*;

  typedef enum logic [1:0] {SQ_IDLE, SQ_SETUP, SQ_LOAD, SQ_DIV} sq_t;
  typedef enum logic [1:0] {JOB_ROW, JOB_COL, JOB_IDX, JOB_RC} job_t;

  // per-axis offset, already reduced below the axis size
  function automatic logic [SIZE_W-1:0] axis_offset(input logic [SIZE_W-1:0] n,
                                                     input logic [HOT_W-1:0]  hot,
                                                     input shift_mode_t       mode);
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] off;
    begin
      h = (SIZE_W'(hot) < n) ? SIZE_W'(hot) : '0;
      case (mode)
        MODE_FFTSHIFT:  off = n >> 1;
        MODE_IFFTSHIFT: off = (n == SIZE_W'(1)) ? '0 : ((n + SIZE_W'(1)) >> 1);
        MODE_UNC_FWD:   off = h;
        MODE_UNC_INV:   off = (h == '0) ? '0 : (n - h);
        default:        off = '0;
      endcase
      return off;
    end
  endfunction

  // configuration registers
  logic [SIZE_W-1:0] frame_rows_r, frame_cols_r;
  shift_mode_t       shift_mode_r;
  logic [HOT_W-1:0]  hot_row_r, hot_col_r;

  // frame control state
  logic              write_bank_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [IDX_W-1:0]  out_index_r;
  logic              frame_ready_r;
  logic [TOTAL_W-1:0] total_r;

  // derived positions: shifted write coordinate and raster read coordinate
  logic [ROW_W-1:0]  dr_r, out_row_r;
  logic [COL_W-1:0]  dc_r, out_col_r;

  // read pipeline and output register
  logic              s1_valid_r, s1_last_r;
  logic              out_valid_r, out_last_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  // recompute sequencer and shared restoring divider
  sq_t               sq_r;
  job_t              job_r;
  logic [IDX_W-1:0]  div_num_r, div_rem_r, div_quo_r;
  logic [TOTAL_W-1:0] div_den_r;
  logic [CNT_W-1:0]  div_cnt_r;

  logic [SIZE_W-1:0] rows_eff, cols_eff, off_row, off_col;
  logic              cfg_fire, in_fire, is_write, s1_adv;
  logic              col_wrap, row_wrap, rd_last, frame_done;
  logic [SIZE_W-1:0] dc_inc, dr_inc, oc_inc;
  logic [COL_W-1:0]  dc_step;
  logic [ROW_W-1:0]  dr_step;
  logic [TOTAL_W-1:0] div_shift, div_rem_nxt;
  logic              div_ge, div_last;
  logic [IDX_W-1:0]  div_quo_nxt;
  logic              ld_dr, ld_dc, ld_rc;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  // sizes saturate to 1..max
  always_comb begin
    rows_eff = frame_rows_r;
    if (frame_rows_r == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (frame_rows_r > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end
    cols_eff = frame_cols_r;
    if (frame_cols_r == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (frame_cols_r > SIZE_W'(MAX_COLS)) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end
  end

  assign off_row = axis_offset(rows_eff, hot_row_r, shift_mode_r);
  assign off_col = axis_offset(cols_eff, hot_col_r, shift_mode_r);

  // handshakes: a new transaction enters when no recompute pass runs and the read stage can move on
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = (sq_r == SQ_IDLE) && (!s1_valid_r || s1_adv);
  assign in_fire   = in_valid && in_ready;
  assign is_write  = (in_opcode == OP_WRITE);

  // raster counter wraps on the input side
  assign col_wrap   = (SIZE_W'(in_col_r) + SIZE_W'(1)) >= cols_eff;
  assign row_wrap   = (SIZE_W'(in_row_r) + SIZE_W'(1)) >= rows_eff;
  assign frame_done = in_fire && is_write && col_wrap && row_wrap;

  // shifted coordinates step with the raster counters, wrapping at the size
  assign dc_inc  = SIZE_W'(dc_r) + SIZE_W'(1);
  assign dr_inc  = SIZE_W'(dr_r) + SIZE_W'(1);
  assign dc_step = (dc_inc == cols_eff) ? '0 : dc_inc[COL_W-1:0];
  assign dr_step = (dr_inc == rows_eff) ? '0 : dr_inc[ROW_W-1:0];

  // read side: last sample of the frame, or any index past a shrunk frame
  assign rd_last = (TOTAL_W'(out_index_r) + TOTAL_W'(1)) >= total_r;
  assign oc_inc  = SIZE_W'(out_col_r) + SIZE_W'(1);

  // store ports: bank bit on top, then row and column
  assign wr_en   = in_fire && is_write;
  assign wr_addr = {write_bank_r, dr_r, dc_r};
  assign rd_en   = in_fire && frame_ready_r;
  assign rd_addr = {~write_bank_r, out_row_r, out_col_r};

  fsr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // config registers, frame counters, read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= SIZE_W'(MAX_ROWS);
      frame_cols_r  <= SIZE_W'(MAX_COLS);
      shift_mode_r  <= MODE_FFTSHIFT;
      hot_row_r     <= '0;
      hot_col_r     <= '0;
      write_bank_r  <= 1'b0;
      in_row_r      <= '0;
      in_col_r      <= '0;
      out_index_r   <= '0;
      frame_ready_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          CFG_FRAME_ROWS: frame_rows_r <= cfg_data;
          CFG_FRAME_COLS: frame_cols_r <= cfg_data;
          CFG_SHIFT_MODE: shift_mode_r <= shift_mode_t'(cfg_data[MODE_W-1:0]);
          CFG_HOT_ROW:    hot_row_r    <= cfg_data[HOT_W-1:0];
          CFG_HOT_COL:    hot_col_r    <= cfg_data[HOT_W-1:0];
          default: ;
        endcase
      end

      // output register takes the registered read data when the read stage advances
      if (s1_adv) begin
        out_valid_r  <= 1'b1;
        out_last_r   <= s1_last_r;
        out_sample_r <= rd_data;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        s1_valid_r <= frame_ready_r;
        s1_last_r  <= rd_last;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (in_fire) begin
        // a completed write frame wins over the read step
        if (frame_done) begin
          out_index_r   <= '0;
          frame_ready_r <= 1'b1;
        end else if (frame_ready_r) begin
          if (rd_last) begin
            out_index_r   <= '0;
            frame_ready_r <= 1'b0;
          end else begin
            out_index_r <= out_index_r + IDX_W'(1);
          end
        end
        if (is_write) begin
          if (col_wrap) begin
            in_col_r <= '0;
            if (row_wrap) begin
              in_row_r     <= '0;
              write_bank_r <= ~write_bank_r;
            end else begin
              in_row_r <= in_row_r + ROW_W'(1);
            end
          end else begin
            in_col_r <= in_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  // derived coordinates: loaded by the recompute pass, stepped per transaction
  always_ff @(posedge clk) begin
    if (ld_dr) begin
      dr_r <= div_rem_nxt[ROW_W-1:0];
    end else if (in_fire && is_write && col_wrap) begin
      dr_r <= row_wrap ? off_row[ROW_W-1:0] : dr_step;
    end

    if (ld_dc) begin
      dc_r <= div_rem_nxt[COL_W-1:0];
    end else if (in_fire && is_write) begin
      dc_r <= col_wrap ? off_col[COL_W-1:0] : dc_step;
    end

    if (ld_rc) begin
      out_row_r <= div_quo_nxt[ROW_W-1:0];
      out_col_r <= div_rem_nxt[COL_W-1:0];
    end else if (frame_done || (in_fire && frame_ready_r && rd_last)) begin
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (in_fire && frame_ready_r) begin
      if (oc_inc == cols_eff) begin
        out_col_r <= '0;
        out_row_r <= out_row_r + ROW_W'(1);
      end else begin
        out_col_r <= oc_inc[COL_W-1:0];
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_shift   = {div_rem_r, div_num_r[IDX_W-1]};
  assign div_ge      = div_shift >= div_den_r;
  assign div_rem_nxt = div_ge ? (div_shift - div_den_r) : div_shift;
  assign div_quo_nxt = {div_quo_r[IDX_W-2:0], div_ge};
  assign div_last    = (div_cnt_r == CNT_W'(IDX_W - 1));

  assign ld_dr = (sq_r == SQ_DIV) && div_last && (job_r == JOB_ROW);
  assign ld_dc = (sq_r == SQ_DIV) && div_last && (job_r == JOB_COL);
  assign ld_rc = (sq_r == SQ_DIV) && div_last && (job_r == JOB_RC);

  // recompute pass: write row and column mod size, then read index mod total,
  // then split that into row and column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= SQ_SETUP;
      job_r <= JOB_ROW;
    end else if (cfg_fire) begin
      sq_r <= SQ_SETUP;
    end else begin
      case (sq_r)
        SQ_IDLE: ;
        SQ_SETUP: begin
          total_r <= TOTAL_W'(rows_eff) * TOTAL_W'(cols_eff);
          job_r   <= JOB_ROW;
          sq_r    <= SQ_LOAD;
        end
        SQ_LOAD: begin
          if (job_r == JOB_ROW) begin
            div_num_r <= IDX_W'(in_row_r) + IDX_W'(off_row);
            div_den_r <= TOTAL_W'(rows_eff);
          end else begin
            div_num_r <= IDX_W'(in_col_r) + IDX_W'(off_col);
            div_den_r <= TOTAL_W'(cols_eff);
          end
          div_rem_r <= '0;
          div_quo_r <= '0;
          div_cnt_r <= '0;
          sq_r      <= SQ_DIV;
        end
        SQ_DIV: begin
          if (div_last) begin
            div_rem_r <= '0;
            div_quo_r <= '0;
            div_cnt_r <= '0;
            case (job_r)
              JOB_ROW: begin
                job_r <= JOB_COL;
                sq_r  <= SQ_LOAD;
              end
              JOB_COL: begin
                job_r     <= JOB_IDX;
                div_num_r <= out_index_r;
                div_den_r <= total_r;
              end
              JOB_IDX: begin
                // remainder feeds straight into the row/column split
                job_r     <= JOB_RC;
                div_num_r <= div_rem_nxt[IDX_W-1:0];
                div_den_r <= TOTAL_W'(cols_eff);
              end
              JOB_RC: sq_r <= SQ_IDLE;
              default: sq_r <= SQ_IDLE;
            endcase
          end else begin
            div_num_r <= div_num_r << 1;
            div_rem_r <= div_rem_nxt[IDX_W-1:0];
            div_quo_r <= div_quo_nxt;
            div_cnt_r <= div_cnt_r + CNT_W'(1);
          end
        end
        default: sq_r <= SQ_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_frame_last = out_last_r;

  `FSR_ASSERT(a_bank_split, wr_en && rd_en, wr_addr[ADDR_W-1] != rd_addr[ADDR_W-1], "read and write hit the same bank")
  `FSR_ASSERT(a_wr_col_range, sq_r == SQ_IDLE, SIZE_W'(dc_r) < cols_eff, "shifted column out of range")
  `FSR_ASSERT(a_wr_row_range, sq_r == SQ_IDLE, SIZE_W'(dr_r) < rows_eff, "shifted row out of range")
  `FSR_ASSERT(a_rd_col_range, (sq_r == SQ_IDLE) && frame_ready_r, SIZE_W'(out_col_r) < cols_eff, "read column out of range")
  `FSR_ASSERT_NEXT(a_frame_swap, frame_done, frame_ready_r && (out_index_r == '0), "completed frame not ready for read")
  `FSR_ASSERT_NEXT(a_read_moves, s1_valid_r && !out_valid_r, out_valid_r, "read data stuck in read stage")

endmodule

FILE: tb/sv/fft_shift_2d_reorder_test.sv
// self-checking testbench for the fft shift 2d reorder block: random raster traffic
// under changing frame sizes and shift modes, checked against an in-bench frame model
// depends on fsr_pkg and fft_shift_2d_reorder
`timescale 1ns / 1ps

module fft_shift_2d_reorder_test;
  import fsr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;   // margin after the last result before the next phase
  localparam int SMALL_MAX     = 8;   // random frames stay inside the primed 8x8 corner
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;
  } raster_item_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } shifted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = OP_WRITE;
  logic [SAMPLE_BITS-1:0] in_sample = '0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   out_frame_last;

  fft_shift_2d_reorder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_frame_last (out_frame_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pending raster transactions and the shifted samples they are expected to produce
  raster_item_t raster_q[$];
  shifted_t     shifted_q[$];
  int           n_queued = 0;   // transactions handed to the driver
  int           in_sent = 0;    // transactions the driver has put on the bus
  int           in_taken = 0;   // transactions the block accepted
  int           err_count = 0;
  int           cycle_count = 0;

  // frame model: configuration copy, two banks and the raster counters
  logic [SIZE_W-1:0]      cur_rows = 7'd64;
  logic [SIZE_W-1:0]      cur_cols = 7'd64;
  shift_mode_t            cur_mode = MODE_FFTSHIFT;
  logic [HOT_W-1:0]       cur_hot_row = '0;
  logic [HOT_W-1:0]       cur_hot_col = '0;
  logic [SAMPLE_BITS-1:0] frame_mem [STORE_DEPTH];
  logic                   wr_bank = 1'b0;
  logic [ROW_W-1:0]       row_cnt = '0;
  logic [COL_W-1:0]       col_cnt = '0;
  logic [IDX_W-1:0]       rd_index = '0;
  logic                   have_frame = 1'b0;

  function automatic int unsigned sat_size(input logic [SIZE_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // per-axis write offset; a hot point outside the axis counts as zero
  function automatic int unsigned axis_shift(input int unsigned n, input int unsigned hot);
    int unsigned h;
    h = (hot < n) ? hot : 0;
    case (cur_mode)
      MODE_FFTSHIFT:  return n / 2;
      MODE_IFFTSHIFT: return (n + 1) / 2;
      MODE_UNC_FWD:   return h;
      default:        return (n - h) % n;
    endcase
  endfunction

  // one accepted transaction: read side first, then the shifted write
  task automatic reorder_step(input logic op, input logic [SAMPLE_BITS-1:0] smp);
    int unsigned rows, cols, total, pos, dr, dc;
    shifted_t    res;
    rows  = sat_size(cur_rows, MAX_ROWS);
    cols  = sat_size(cur_cols, MAX_COLS);
    total = rows * cols;
    if (have_frame) begin
      // an index past a shrunken frame wraps and ends the frame
      pos = rd_index % total;
      res.sample = frame_mem[(wr_bank ? 0 : BANK_DEPTH) + (pos / cols) * MAX_COLS + pos % cols];
      res.last = (rd_index >= total - 1);
      shifted_q.insert(shifted_q.size(), res);
      if (res.last) begin
        rd_index = '0;
        have_frame = 1'b0;
      end else begin
        rd_index++;
      end
    end
    if (op == OP_WRITE) begin
      dr = (row_cnt + axis_shift(rows, cur_hot_row)) % rows;
      dc = (col_cnt + axis_shift(cols, cur_hot_col)) % cols;
      frame_mem[(wr_bank ? BANK_DEPTH : 0) + dr * MAX_COLS + dc] = smp;
      if (col_cnt + 1 >= cols) begin
        col_cnt = '0;
        if (row_cnt + 1 >= rows) begin
          // frame complete: swap banks, any unread output is dropped
          row_cnt = '0;
          wr_bank = ~wr_bank;
          have_frame = 1'b1;
          rd_index = '0;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
    end
  endtask

  task automatic flag_error(input string msg);
    if (err_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input logic op, input logic [SAMPLE_BITS-1:0] smp);
    raster_item_t it;
    it.op = op;
    it.sample = smp;
    raster_q.insert(raster_q.size(), it);
    n_queued++;
  endtask

  // all transactions accepted, all results seen, then a few quiet cycles
  task automatic wait_idle();
    @(negedge clk);
    while (!(in_taken == n_queued && shifted_q.size() == 0)) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write transaction, mirrored into the model once accepted
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FRAME_ROWS: cur_rows = val;
      CFG_FRAME_COLS: cur_cols = val;
      CFG_SHIFT_MODE: cur_mode = shift_mode_t'(val[MODE_W-1:0]);
      CFG_HOT_ROW:    cur_hot_row = val[HOT_W-1:0];
      CFG_HOT_COL:    cur_hot_col = val[HOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // half the time a hot point that can land inside a small frame
  function automatic logic [CFG_DATA_W-1:0] pick_hot();
    if ($urandom_range(0, 1)) return 7'($urandom_range(0, SMALL_MAX));
    return 7'($urandom_range(0, 63));
  endfunction

  // a few register writes, then a burst of writes and drains with no regard to frame edges
  task automatic run_random_phase();
    int n_items;
    bit any_cfg;
    any_cfg = 1'b0;
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_FRAME_ROWS, 7'($urandom_range(0, SMALL_MAX)));
      any_cfg = 1'b1;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_FRAME_COLS, 7'($urandom_range(0, SMALL_MAX)));
      any_cfg = 1'b1;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_SHIFT_MODE, 7'($urandom_range(0, 3)));
      any_cfg = 1'b1;
    end
    if ($urandom_range(0, 1)) write_reg(CFG_HOT_ROW, pick_hot());
    if ($urandom_range(0, 1)) write_reg(CFG_HOT_COL, pick_hot());
    if (!any_cfg) write_reg(CFG_FRAME_COLS, 7'($urandom_range(0, SMALL_MAX)));
    n_items = $urandom_range(4, 40);
    repeat (n_items) push_item(($urandom_range(0, 3) == 0) ? OP_DRAIN : OP_WRITE, rand64());
    wait_idle();
  endtask

  // full-height or full-width frame with out-of-range size values that saturate
  task automatic run_tall_phase(input logic [CFG_DATA_W-1:0] rows_val,
                                input logic [CFG_DATA_W-1:0] cols_val, input int frame_len);
    // close the frame in progress and read it out so the big frame starts clean
    while (row_cnt != 0 || col_cnt != 0) begin
      push_item(OP_WRITE, rand64());
      wait_idle();
    end
    while (have_frame) begin
      push_item(OP_DRAIN, rand64());
      wait_idle();
    end
    write_reg(CFG_FRAME_ROWS, rows_val);
    write_reg(CFG_FRAME_COLS, cols_val);
    write_reg(CFG_SHIFT_MODE, 7'($urandom_range(0, 3)));
    write_reg(CFG_HOT_ROW, 7'($urandom_range(0, 63)));
    write_reg(CFG_HOT_COL, 7'($urandom_range(0, 63)));
    repeat (frame_len) push_item(OP_WRITE, rand64());
    repeat (frame_len) push_item(OP_DRAIN, rand64());
    wait_idle();
  endtask

  // driver: sender in bursts with gaps, receiver on a rotating stall pattern
  raster_item_t next_item;
  int           burst_left = 1;
  int           gap_left = 0;
  logic [15:0]  ready_pat = '1;
  int           pat_left = 0;

  always @(negedge clk) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat = '1;
        1: ready_pat = 16'($urandom);
        2: ready_pat = 16'h00FF;
        default: ready_pat = 16'h0F0F;
      endcase
      pat_left = 16;
    end
    out_ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    pat_left--;

    if (in_valid && in_taken != in_sent) begin
      // transaction still waiting for in_ready, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (raster_q.size() > 0) begin
      next_item = raster_q.pop_front();
      in_opcode <= next_item.op;
      in_sample <= next_item.sample;
      in_valid  <= 1'b1;
      in_sent++;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor: check each accepted result, then predict from each accepted input
  shifted_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (shifted_q.size() == 0) begin
          flag_error($sformatf("unexpected result, sample %h last %b", out_sample,
                               out_frame_last));
        end else begin
          want = shifted_q.pop_front();
          if (out_sample !== want.sample)
            flag_error($sformatf("out_sample expected %h, got %h", want.sample, out_sample));
          if (out_frame_last !== want.last)
            flag_error($sformatf("out_frame_last expected %b, got %b", want.last,
                                 out_frame_last));
        end
      end
      if (in_valid && in_ready) begin
        reorder_step(in_opcode, in_sample);
        in_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fft_shift_2d_reorder_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // drains with no finished frame give nothing back
    push_item(OP_DRAIN, '1);
    push_item(OP_DRAIN, '0);
    wait_idle();

    // fill the 8x8 corner of both banks so later size changes never read stale space
    write_reg(CFG_FRAME_ROWS, 7'd8);
    write_reg(CFG_FRAME_COLS, 7'd8);
    push_item(OP_WRITE, '0);
    push_item(OP_WRITE, '1);
    push_item(OP_WRITE, {32{2'b10}});
    push_item(OP_WRITE, {32{2'b01}});
    repeat (2 * 64 - 4) push_item(OP_WRITE, rand64());
    wait_idle();

    // shrink to 2x2 under uncentered forward, hot column beyond the size
    write_reg(CFG_FRAME_ROWS, 7'd2);
    write_reg(CFG_FRAME_COLS, 7'd2);
    write_reg(CFG_SHIFT_MODE, 7'(MODE_UNC_FWD));
    write_reg(CFG_HOT_ROW, 7'd1);
    write_reg(CFG_HOT_COL, 7'd63);
    repeat (6) push_item(OP_WRITE, rand64());
    wait_idle();

    // widen mid-frame: the new frame closes before the old one is read out
    write_reg(CFG_FRAME_COLS, 7'd4);
    write_reg(CFG_SHIFT_MODE, 7'(MODE_UNC_INV));
    write_reg(CFG_HOT_ROW, 7'd63);
    write_reg(CFG_HOT_COL, 7'd3);
    repeat (4) push_item(OP_WRITE, rand64());
    repeat (3) push_item(OP_DRAIN, rand64());
    wait_idle();

    while (n_queued < 200) run_random_phase();
    run_tall_phase(7'd127, 7'd0, MAX_ROWS);
    while (n_queued < 360) run_random_phase();
    run_tall_phase(7'd0, 7'd127, MAX_COLS);
    while (n_queued < 540) run_random_phase();

    wait_idle();
    if (err_count == 0) begin
      $display("fft_shift_2d_reorder_test: clean");
    end else begin
      $display("fft_shift_2d_reorder_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fsr_pkg.sv
hdl/fsr_ram.sv
hdl/fft_shift_2d_reorder.sv
tb/sv/fft_shift_2d_reorder_test.sv
